>>> hdl/ecv_pkg.sv
`timescale 1ns / 1ps
package ecv_pkg;

  localparam int AngleBitsDef = 16;
  localparam int VecFrac      = 14;
  localparam int VecW         = 18;
  localparam int CordW        = 34;
  localparam int CordSteps    = 30;
  localparam int ProdW        = 50;
  localparam int AccW         = 51;

  localparam logic signed [VecW-1:0]  VecOne = VecW'(2 ** VecFrac);
  localparam logic signed [CordW-1:0] CordX0 = CordW'(652032874);

  typedef enum logic [2:0] {
    CFG_EYE_X = 3'd0,
    CFG_EYE_Y = 3'd1,
    CFG_EYE_Z = 3'd2,
    CFG_UP_X  = 3'd3,
    CFG_UP_Y  = 3'd4,
    CFG_UP_Z  = 3'd5
  } cfg_idx_e;

  typedef enum logic [3:0] {
    SA_CYAW, SA_SYAW, SA_SPIT, SA_FX, SA_FZ, SA_CX, SA_CY, SA_CZ,
    SA_RX, SA_RY, SA_RZ, SA_VX, SA_VY, SA_VZ
  } src_a_e;

  typedef enum logic [3:0] {
    SB_CPIT, SB_UX, SB_UY, SB_UZ, SB_FX, SB_FZ, SB_SPIT, SB_CX, SB_CY, SB_CZ,
    SB_EX, SB_EY, SB_EZ
  } src_b_e;

  typedef enum logic [3:0] {
    DST_NONE, DST_FX, DST_FZ, DST_CX, DST_CY, DST_CZ, DST_SUMSQ,
    DST_VX, DST_VY, DST_VZ, DST_SH_SIDE, DST_SH_UP, DST_SH_BACK
  } dst_e;

  // one multiply-accumulate step of the sequencer
  typedef struct packed {
    src_a_e a;
    src_b_e b;
    logic   acc;
    logic   neg;
    logic   rnd;
    dst_e   dst;
  } uop_t;

  localparam logic [4:0] UopSumsq     = 5'd10;
  localparam logic [4:0] UopAfterRoot = 5'd11;
  localparam logic [4:0] UopLast      = 5'd25;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051D;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2E;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2F9;
      5'd15: v = 32'h0000517C;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A2F;
      5'd19: v = 32'h00000517;
      5'd20: v = 32'h0000028B;
      5'd21: v = 32'h00000145;
      5'd22: v = 32'h000000A2;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000028;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000002;
      5'd29: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  // microprogram: front, cross with world up, squared length, up, translations
  function automatic uop_t uop_rom(input logic [4:0] idx);
    uop_t u;
    unique case (idx)
      5'd0:  u = '{SA_CYAW, SB_CPIT, 1'b0, 1'b0, 1'b0, DST_FX};
      5'd1:  u = '{SA_SYAW, SB_CPIT, 1'b0, 1'b0, 1'b0, DST_FZ};
      5'd2:  u = '{SA_SPIT, SB_UZ,   1'b0, 1'b0, 1'b0, DST_NONE};
      5'd3:  u = '{SA_FZ,   SB_UY,   1'b1, 1'b1, 1'b0, DST_CX};
      5'd4:  u = '{SA_FZ,   SB_UX,   1'b0, 1'b0, 1'b0, DST_NONE};
      5'd5:  u = '{SA_FX,   SB_UZ,   1'b1, 1'b1, 1'b0, DST_CY};
      5'd6:  u = '{SA_FX,   SB_UY,   1'b0, 1'b0, 1'b0, DST_NONE};
      5'd7:  u = '{SA_SPIT, SB_UX,   1'b1, 1'b1, 1'b0, DST_CZ};
      5'd8:  u = '{SA_CX,   SB_CX,   1'b0, 1'b0, 1'b0, DST_NONE};
      5'd9:  u = '{SA_CY,   SB_CY,   1'b1, 1'b0, 1'b0, DST_NONE};
      5'd10: u = '{SA_CZ,   SB_CZ,   1'b1, 1'b0, 1'b0, DST_SUMSQ};
      5'd11: u = '{SA_RY,   SB_FZ,   1'b0, 1'b0, 1'b0, DST_NONE};
      5'd12: u = '{SA_RZ,   SB_SPIT, 1'b1, 1'b1, 1'b0, DST_VX};
      5'd13: u = '{SA_RZ,   SB_FX,   1'b0, 1'b0, 1'b0, DST_NONE};
      5'd14: u = '{SA_RX,   SB_FZ,   1'b1, 1'b1, 1'b0, DST_VY};
      5'd15: u = '{SA_RX,   SB_SPIT, 1'b0, 1'b0, 1'b0, DST_NONE};
      5'd16: u = '{SA_RY,   SB_FX,   1'b1, 1'b1, 1'b0, DST_VZ};
      5'd17: u = '{SA_RX,   SB_EX,   1'b0, 1'b0, 1'b1, DST_NONE};
      5'd18: u = '{SA_RY,   SB_EY,   1'b1, 1'b0, 1'b1, DST_NONE};
      5'd19: u = '{SA_RZ,   SB_EZ,   1'b1, 1'b0, 1'b1, DST_SH_SIDE};
      5'd20: u = '{SA_VX,   SB_EX,   1'b0, 1'b0, 1'b1, DST_NONE};
      5'd21: u = '{SA_VY,   SB_EY,   1'b1, 1'b0, 1'b1, DST_NONE};
      5'd22: u = '{SA_VZ,   SB_EZ,   1'b1, 1'b0, 1'b1, DST_SH_UP};
      5'd23: u = '{SA_FX,   SB_EX,   1'b0, 1'b0, 1'b1, DST_NONE};
      5'd24: u = '{SA_SPIT, SB_EY,   1'b1, 1'b0, 1'b1, DST_NONE};
      5'd25: u = '{SA_FZ,   SB_EZ,   1'b1, 1'b0, 1'b1, DST_SH_BACK};
      default: u = '{SA_CYAW, SB_CPIT, 1'b0, 1'b0, 1'b0, DST_NONE};
    endcase
    return u;
  endfunction

endpackage

>>> hdl/euler_camera_view_matrix.sv
`timescale 1ns / 1ps
// Euler-angle camera: each input transaction adds a yaw and a pitch offset to
// the stored angles (fractions of a turn, wrapping) and returns one look-at
// view matrix: rows right, up and minus front in Q2.14, and three saturated
// Q16.16 translations for the configured eye. The result register loads when
// the sequencer finishes, and the next transaction can be taken once it has
// returned to idle. The sequencer runs two 30-step CORDIC runs in a shared
// rotator, 26 multiply-accumulate steps on one shared 18 x 32 multiplier, a
// 16-step square root, three runs of one divider (a load, then quotient steps)
// and the load of the result. A front parallel to world up skips the divider.
// Input is taken only while the sequencer is idle; the result sits in an output
// register, so the next transaction may start while it waits to be taken, and a
// result still held there stalls the sequencer before its next load.
module euler_camera_view_matrix #(
  parameter int ANGLE_BITS = ecv_pkg::AngleBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] yaw_offset_i,
  input  logic signed [15:0] pitch_offset_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] side_x_o,
  output logic signed [15:0] side_y_o,
  output logic signed [15:0] side_z_o,
  output logic signed [15:0] upward_x_o,
  output logic signed [15:0] upward_y_o,
  output logic signed [15:0] upward_z_o,
  output logic signed [15:0] back_x_o,
  output logic signed [15:0] back_y_o,
  output logic signed [15:0] back_z_o,
  output logic signed [31:0] shift_side_o,
  output logic signed [31:0] shift_up_o,
  output logic signed [31:0] shift_back_o
);

  localparam int VW = ecv_pkg::VecW;
  localparam int AW = ecv_pkg::AccW;
  localparam logic signed [AW-1:0] AccHalf = AW'(2 ** (ecv_pkg::VecFrac - 1));
  localparam logic signed [AW-1:0] AccOne  = AW'(ecv_pkg::VecOne);
  localparam logic signed [AW-1:0] SatHi   = AW'(64'sd2147483647);
  localparam logic signed [AW-1:0] SatLo   = -AW'(64'sd2147483648);

  typedef enum logic [2:0] {
    S_IDLE, S_YAW, S_PITCH, S_MUL, S_SQRT, S_DLOAD, S_DIV, S_DONE
  } state_e;

  // configuration
  logic signed [31:0] eye_x_q, eye_y_q, eye_z_q;
  logic signed [15:0] wup_x_q, wup_y_q, wup_z_q;
  logic signed [VW-1:0] ux, uy, uz;

  // angles
  logic [ANGLE_BITS-1:0] yaw_q, pitch_q;
  logic signed [39:0]    yaw_ext, pit_ext, yaw_du, pit_du;

  // sequencer
  state_e     state_q;
  logic       phase_q;
  logic [4:0] uop_q;
  logic [3:0] bit_q;
  logic [1:0] comp_q;
  logic       cord_start_q;
  logic       accept;
  ecv_pkg::uop_t uop;

  // working values
  logic signed [VW-1:0] cyaw_q, syaw_q, cpit_q, spit_q, fx_q, fz_q;
  logic signed [VW-1:0] cx_q, cy_q, cz_q, rx_q, ry_q, rz_q, vx_q, vy_q, vz_q;
  logic signed [31:0]   sh_side_q, sh_up_q, sh_back_q;

  // shared multiplier and accumulator
  logic signed [VW-1:0]              a_val;
  logic signed [31:0]                b_val;
  logic signed [ecv_pkg::ProdW-1:0]  prod_q;
  logic signed [AW-1:0]              acc_q, term_r, term_n, acc_d, acc_rnd, acc_neg;
  logic signed [VW-1:0]              rnd_v, clamp_v;
  logic signed [31:0]                sat_pos, sat_neg;

  // square root and divider
  logic [31:0] sq_q;
  logic [17:0] srem_q;
  logic [19:0] srem_n, trial;
  logic        sq_ge;
  logic [15:0] root_q, root_n, len_q;
  logic [15:0] rem_q, num_q, quo_q, quo_n, qclamp;
  logic [16:0] rem_n;
  logic        div_ge, cneg_q;
  logic signed [VW-1:0] c_sel, c_abs, r_val;
  logic [29:0] numer;

  // rotator
  logic                 cord_done;
  logic [31:0]          cord_ang;
  logic signed [VW-1:0] cord_cos, cord_sin;

  // output register
  logic                 out_valid_q;
  logic signed [15:0]   o_side_x_q, o_side_y_q, o_side_z_q;
  logic signed [15:0]   o_up_x_q, o_up_y_q, o_up_z_q;
  logic signed [15:0]   o_back_x_q, o_back_y_q, o_back_z_q;
  logic signed [31:0]   o_sh_side_q, o_sh_up_q, o_sh_back_q;

  function automatic logic signed [VW-1:0] up_clamp(input logic signed [15:0] v);
    logic signed [VW-1:0] w;
    w = VW'(v);
    if (w > ecv_pkg::VecOne) return ecv_pkg::VecOne;
    if (w < -ecv_pkg::VecOne) return -ecv_pkg::VecOne;
    return w;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [AW-1:0] v);
    if (v > SatHi) return 32'sh7FFFFFFF;
    if (v < SatLo) return 32'sh80000000;
    return v[31:0];
  endfunction

  assign ux = up_clamp(wup_x_q);
  assign uy = up_clamp(wup_y_q);
  assign uz = up_clamp(wup_z_q);

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eye_x_q <= '0;
      eye_y_q <= '0;
      eye_z_q <= '0;
      wup_x_q <= '0;
      wup_y_q <= 16'sd16384;
      wup_z_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ecv_pkg::CFG_EYE_X: eye_x_q <= cfg_data_i;
        ecv_pkg::CFG_EYE_Y: eye_y_q <= cfg_data_i;
        ecv_pkg::CFG_EYE_Z: eye_z_q <= cfg_data_i;
        ecv_pkg::CFG_UP_X:  wup_x_q <= cfg_data_i[15:0];
        ecv_pkg::CFG_UP_Y:  wup_y_q <= cfg_data_i[15:0];
        ecv_pkg::CFG_UP_Z:  wup_z_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // offsets scaled to the angle width; floor when narrower than 16 bits
  always_comb begin
    yaw_ext = {yaw_offset_i, 24'b0};
    pit_ext = {pitch_offset_i, 24'b0};
    yaw_du  = yaw_ext >>> (40 - ANGLE_BITS);
    pit_du  = pit_ext >>> (40 - ANGLE_BITS);
  end

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);

  assign cord_ang = (state_q == S_YAW) ? 32'({yaw_q, {(32 - ANGLE_BITS){1'b0}}})
                                       : 32'({pitch_q, {(32 - ANGLE_BITS){1'b0}}});

  ecv_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cord_start_q),
    .angle_i (cord_ang),
    .done_o  (cord_done),
    .cos_o   (cord_cos),
    .sin_o   (cord_sin)
  );

  // operand selection and accumulate path
  always_comb begin
    uop = ecv_pkg::uop_rom(uop_q);
    unique case (uop.a)
      ecv_pkg::SA_CYAW: a_val = cyaw_q;
      ecv_pkg::SA_SYAW: a_val = syaw_q;
      ecv_pkg::SA_SPIT: a_val = spit_q;
      ecv_pkg::SA_FX:   a_val = fx_q;
      ecv_pkg::SA_FZ:   a_val = fz_q;
      ecv_pkg::SA_CX:   a_val = cx_q;
      ecv_pkg::SA_CY:   a_val = cy_q;
      ecv_pkg::SA_CZ:   a_val = cz_q;
      ecv_pkg::SA_RX:   a_val = rx_q;
      ecv_pkg::SA_RY:   a_val = ry_q;
      ecv_pkg::SA_RZ:   a_val = rz_q;
      ecv_pkg::SA_VX:   a_val = vx_q;
      ecv_pkg::SA_VY:   a_val = vy_q;
      ecv_pkg::SA_VZ:   a_val = vz_q;
      default:          a_val = '0;
    endcase
    unique case (uop.b)
      ecv_pkg::SB_CPIT: b_val = 32'(cpit_q);
      ecv_pkg::SB_UX:   b_val = 32'(ux);
      ecv_pkg::SB_UY:   b_val = 32'(uy);
      ecv_pkg::SB_UZ:   b_val = 32'(uz);
      ecv_pkg::SB_FX:   b_val = 32'(fx_q);
      ecv_pkg::SB_FZ:   b_val = 32'(fz_q);
      ecv_pkg::SB_SPIT: b_val = 32'(spit_q);
      ecv_pkg::SB_CX:   b_val = 32'(cx_q);
      ecv_pkg::SB_CY:   b_val = 32'(cy_q);
      ecv_pkg::SB_CZ:   b_val = 32'(cz_q);
      ecv_pkg::SB_EX:   b_val = eye_x_q;
      ecv_pkg::SB_EY:   b_val = eye_y_q;
      ecv_pkg::SB_EZ:   b_val = eye_z_q;
      default:          b_val = '0;
    endcase

    term_r  = uop.rnd ? ((AW'(prod_q) + AccHalf) >>> ecv_pkg::VecFrac) : AW'(prod_q);
    term_n  = uop.neg ? -term_r : term_r;
    acc_d   = uop.acc ? (acc_q + term_n) : term_n;
    acc_rnd = (acc_d + AccHalf) >>> ecv_pkg::VecFrac;
    acc_neg = -acc_d;
    rnd_v   = acc_rnd[VW-1:0];
    if (acc_rnd > AccOne) clamp_v = ecv_pkg::VecOne;
    else if (acc_rnd < -AccOne) clamp_v = -ecv_pkg::VecOne;
    else clamp_v = acc_rnd[VW-1:0];
    sat_pos = sat32(acc_d);
    // side and up translations clamp symmetrically
    sat_neg = sat32(acc_neg);
    if (sat_neg == 32'sh80000000) sat_neg = -32'sh7FFFFFFF;
  end

  // one root bit pair and one quotient bit a cycle
  always_comb begin
    srem_n = {srem_q, sq_q[31:30]};
    trial  = {2'b00, root_q, 2'b01};
    sq_ge  = (srem_n >= trial);
    root_n = {root_q[14:0], sq_ge};

    unique case (comp_q)
      2'd0:    c_sel = cx_q;
      2'd1:    c_sel = cy_q;
      default: c_sel = cz_q;
    endcase
    c_abs = c_sel[VW-1] ? -c_sel : c_sel;
    numer = {c_abs[15:0], 14'b0} + {15'b0, len_q[15:1]};

    rem_n  = {rem_q, num_q[15]};
    div_ge = (rem_n >= {1'b0, len_q});
    quo_n  = {quo_q[14:0], div_ge};
    qclamp = (quo_n > 16'(ecv_pkg::VecOne)) ? 16'(ecv_pkg::VecOne) : quo_n;
    r_val  = cneg_q ? -VW'(qclamp) : VW'(qclamp);
  end

  // sequencer, working registers and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      phase_q      <= 1'b0;
      uop_q        <= '0;
      bit_q        <= '0;
      comp_q       <= '0;
      cord_start_q <= 1'b0;
      out_valid_q  <= 1'b0;
      yaw_q        <= ANGLE_BITS'(3) << (ANGLE_BITS - 2);
      pitch_q      <= '0;
    end else begin
      cord_start_q <= 1'b0;
      if (out_valid_q && !out_stall_i && state_q != S_DONE) out_valid_q <= 1'b0;

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            yaw_q        <= yaw_q + yaw_du[ANGLE_BITS-1:0];
            pitch_q      <= pitch_q + pit_du[ANGLE_BITS-1:0];
            cord_start_q <= 1'b1;
            state_q      <= S_YAW;
          end
        end
        S_YAW: begin
          if (cord_done) begin
            cyaw_q       <= cord_cos;
            syaw_q       <= cord_sin;
            cord_start_q <= 1'b1;
            state_q      <= S_PITCH;
          end
        end
        S_PITCH: begin
          if (cord_done) begin
            cpit_q  <= cord_cos;
            spit_q  <= cord_sin;
            uop_q   <= '0;
            phase_q <= 1'b0;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          if (!phase_q) begin
            prod_q  <= a_val * b_val;
            phase_q <= 1'b1;
          end else begin
            acc_q   <= acc_d;
            phase_q <= 1'b0;
            unique case (uop.dst)
              ecv_pkg::DST_FX:      fx_q <= rnd_v;
              ecv_pkg::DST_FZ:      fz_q <= rnd_v;
              ecv_pkg::DST_CX:      cx_q <= rnd_v;
              ecv_pkg::DST_CY:      cy_q <= rnd_v;
              ecv_pkg::DST_CZ:      cz_q <= rnd_v;
              ecv_pkg::DST_SUMSQ:   sq_q <= acc_d[31:0];
              ecv_pkg::DST_VX:      vx_q <= clamp_v;
              ecv_pkg::DST_VY:      vy_q <= clamp_v;
              ecv_pkg::DST_VZ:      vz_q <= clamp_v;
              ecv_pkg::DST_SH_SIDE: sh_side_q <= sat_neg;
              ecv_pkg::DST_SH_UP:   sh_up_q <= sat_neg;
              ecv_pkg::DST_SH_BACK: sh_back_q <= sat_pos;
              default: ;
            endcase
            if (uop_q == ecv_pkg::UopSumsq) begin
              srem_q  <= '0;
              root_q  <= '0;
              bit_q   <= '0;
              state_q <= S_SQRT;
            end else if (uop_q == ecv_pkg::UopLast) begin
              state_q <= S_DONE;
            end else begin
              uop_q <= uop_q + 5'd1;
            end
          end
        end
        S_SQRT: begin
          srem_q <= 18'(sq_ge ? (srem_n - trial) : srem_n);
          root_q <= root_n;
          sq_q   <= {sq_q[29:0], 2'b00};
          bit_q  <= bit_q + 4'd1;
          if (bit_q == 4'd15) begin
            len_q <= root_n;
            if (root_n == '0) begin
              // front along world up: no side vector
              rx_q    <= '0;
              ry_q    <= '0;
              rz_q    <= '0;
              uop_q   <= ecv_pkg::UopAfterRoot;
              state_q <= S_MUL;
            end else begin
              comp_q  <= '0;
              state_q <= S_DLOAD;
            end
          end
        end
        S_DLOAD: begin
          rem_q   <= {2'b00, numer[29:16]};
          num_q   <= numer[15:0];
          quo_q   <= '0;
          cneg_q  <= c_sel[VW-1];
          bit_q   <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          rem_q <= div_ge ? 16'(rem_n - {1'b0, len_q}) : rem_n[15:0];
          num_q <= {num_q[14:0], 1'b0};
          quo_q <= quo_n;
          bit_q <= bit_q + 4'd1;
          if (bit_q == 4'd15) begin
            unique case (comp_q)
              2'd0:    rx_q <= r_val;
              2'd1:    ry_q <= r_val;
              default: rz_q <= r_val;
            endcase
            if (comp_q == 2'd2) begin
              uop_q   <= ecv_pkg::UopAfterRoot;
              state_q <= S_MUL;
            end else begin
              comp_q  <= comp_q + 2'd1;
              state_q <= S_DLOAD;
            end
          end
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            o_side_x_q  <= rx_q[15:0];
            o_side_y_q  <= ry_q[15:0];
            o_side_z_q  <= rz_q[15:0];
            o_up_x_q    <= vx_q[15:0];
            o_up_y_q    <= vy_q[15:0];
            o_up_z_q    <= vz_q[15:0];
            o_back_x_q  <= 16'(-fx_q);
            o_back_y_q  <= 16'(-spit_q);
            o_back_z_q  <= 16'(-fz_q);
            o_sh_side_q <= sh_side_q;
            o_sh_up_q   <= sh_up_q;
            o_sh_back_q <= sh_back_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign side_x_o     = o_side_x_q;
  assign side_y_o     = o_side_y_q;
  assign side_z_o     = o_side_z_q;
  assign upward_x_o   = o_up_x_q;
  assign upward_y_o   = o_up_y_q;
  assign upward_z_o   = o_up_z_q;
  assign back_x_o     = o_back_x_q;
  assign back_y_o     = o_back_y_q;
  assign back_z_o     = o_back_z_q;
  assign shift_side_o = o_sh_side_q;
  assign shift_up_o   = o_sh_up_q;
  assign shift_back_o = o_sh_back_q;

  // a taken transaction closes the input until the sequencer is done
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input open right after a transaction");

  // divider only runs on a non-zero length
  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV || state_q == S_DLOAD) |-> (len_q != '0))
    else $error("divider running on zero length");

  // rotator finishes only while the sequencer waits for it
  a_cord_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cord_done |-> (state_q == S_YAW || state_q == S_PITCH))
    else $error("rotator result outside angle phase");

  // delivered side x and up y components stay within plus and minus one
  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (side_x_o <= 16'sd16384 && side_x_o >= -16'sd16384 &&
                     upward_y_o <= 16'sd16384 && upward_y_o >= -16'sd16384))
    else $error("unit vector out of range");

endmodule

>>> hdl/ecv_cordic.sv
`timescale 1ns / 1ps
module ecv_cordic (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [31:0]                       angle_i,
  output logic                              done_o,
  output logic signed [ecv_pkg::VecW-1:0]   cos_o,
  output logic signed [ecv_pkg::VecW-1:0]   sin_o
);

  localparam int RndSh = 30 - ecv_pkg::VecFrac;
  localparam logic signed [ecv_pkg::CordW-1:0] RndHalf = ecv_pkg::CordW'(2 ** (RndSh - 1));
  localparam logic signed [ecv_pkg::CordW-1:0] OneW = ecv_pkg::CordW'(ecv_pkg::VecOne);

  logic                               busy_q, done_q, neg_q;
  logic [4:0]                         step_q;
  logic signed [ecv_pkg::CordW-1:0]   x_q, y_q, dx, dy, xr, yr;
  logic signed [32:0]                 z_q, atan_s;
  logic signed [ecv_pkg::VecW-1:0]    cr, sr;

  always_comb begin
    dx     = y_q >>> step_q;
    dy     = x_q >>> step_q;
    atan_s = signed'({1'b0, ecv_pkg::atan_turn(step_q)});
    xr     = (x_q + RndHalf) >>> RndSh;
    yr     = (y_q + RndHalf) >>> RndSh;
    if (xr > OneW) cr = ecv_pkg::VecOne;
    else if (xr < -OneW) cr = -ecv_pkg::VecOne;
    else cr = xr[ecv_pkg::VecW-1:0];
    if (yr > OneW) sr = ecv_pkg::VecOne;
    else if (yr < -OneW) sr = -ecv_pkg::VecOne;
    else sr = yr[ecv_pkg::VecW-1:0];
  end

  assign cos_o  = neg_q ? -cr : cr;
  assign sin_o  = neg_q ? -sr : sr;
  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 5'd1;
        if (step_q == 5'(ecv_pkg::CordSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // left and right half turns fold onto the right half with negated results
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= ecv_pkg::CordX0;
      y_q   <= '0;
      z_q   <= signed'({angle_i[30], angle_i[30], angle_i[30:0]});
      neg_q <= angle_i[31] ^ angle_i[30];
    end else if (busy_q) begin
      if (!z_q[32]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - atan_s;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + atan_s;
      end
    end
  end

endmodule

>>> verif/tb_euler_camera_view_matrix.sv
`timescale 1ns / 1ps
module tb_euler_camera_view_matrix;

  localparam int          WatchLimit  = 6000;   // far above a long hold plus one transaction
  localparam int          LongHold    = 900;
  localparam int          DrainCycles = 400;
  localparam int          RandItems   = 450;
  localparam logic [2:0]  CfgSpare6   = 3'd6;   // indexes past the last register are ignored
  localparam logic [2:0]  CfgSpare7   = 3'd7;
  localparam longint      VOne        = 16384;
  localparam longint      Lim32       = 2147483647;

  // arctangent of 2^-i, units of 2^-32 turn
  localparam logic [31:0] AtanTab [30] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001};

  typedef struct {
    logic signed [15:0] side [3];
    logic signed [15:0] upw  [3];
    logic signed [15:0] back [3];
    logic signed [31:0] sh_side, sh_up, sh_back;
  } view_t;

  typedef struct {
    logic [15:0] yaw, pitch;
    bit          origin;  // eye at origin, so all translations read zero
  } row_t;

  logic clk_i = 1'b0, rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0, out_stall_i = 1'b0;
  logic signed [15:0] yaw_offset_i = '0, pitch_offset_i = '0;
  logic out_valid_o, in_stall_o;
  logic signed [15:0] side_x_o, side_y_o, side_z_o, upward_x_o, upward_y_o, upward_z_o;
  logic signed [15:0] back_x_o, back_y_o, back_z_o;
  logic signed [31:0] shift_side_o, shift_up_o, shift_back_o;
  logic row_origin = 1'b0;

  // mirror of the camera state and registers
  longint      eye [3];
  longint      wup [3];
  logic [15:0] yaw_ang, pitch_ang;

  view_t view_q[$];
  int    n_fail = 0, n_sent = 0, n_seen = 0, n_flat = 0, n_phase = 0;
  bit    calm = 1'b0;
  int    hold_req = 0, hold_ack = 0;

  always #2 clk_i = ~clk_i;

  euler_camera_view_matrix u_top (.*);

  function automatic longint rnd_q(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp_sym(longint v, longint lim);
    return v > lim ? lim : (v < -lim ? -lim : v);
  endfunction

  function automatic void cordic_sc(input logic [15:0] ang, output longint c, output longint s);
    logic [31:0] a;
    bit          flip;
    longint      x, y, z, dx, dy;
    a = {ang, 16'h0000};
    flip = a[31] ^ a[30];  // [1/4, 3/4) turn folded by half a turn
    if (flip) a = a - 32'h80000000;
    z = longint'($signed(a));
    x = 652032874;
    y = 0;
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(AtanTab[i]);
      end else begin
        x += dx; y -= dy; z += longint'(AtanTab[i]);
      end
    end
    x = clamp_sym(rnd_q(x, 16), VOne);
    y = clamp_sym(rnd_q(y, 16), VOne);
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint unit_part(longint c, longint len);
    longint unsigned m, q;
    longint r;
    m = c < 0 ? -c : c;
    q = ((m << 14) + (longint'(len) >> 1)) / len;
    r = clamp_sym(longint'(q), VOne);
    return c < 0 ? -r : r;
  endfunction

  function automatic longint eye_dot(longint ax, longint ay, longint az);
    return rnd_q(ax * eye[0], 14) + rnd_q(ay * eye[1], 14) + rnd_q(az * eye[2], 14);
  endfunction

  // advance the camera angles and form the view matrix
  function automatic view_t predict_view(logic [15:0] dyaw, logic [15:0] dpitch);
    view_t  v;
    longint cy, sy, cp, sp, f[3], u[3], c[3], r[3], w[3], len, t;
    yaw_ang   = yaw_ang + dyaw;
    pitch_ang = pitch_ang + dpitch;
    cordic_sc(yaw_ang, cy, sy);
    cordic_sc(pitch_ang, cp, sp);
    f[0] = rnd_q(cy * cp, 14);
    f[1] = sp;
    f[2] = rnd_q(sy * cp, 14);
    for (int k = 0; k < 3; k++) u[k] = clamp_sym(wup[k], VOne);
    c[0] = rnd_q(f[1] * u[2] - f[2] * u[1], 14);
    c[1] = rnd_q(f[2] * u[0] - f[0] * u[2], 14);
    c[2] = rnd_q(f[0] * u[1] - f[1] * u[0], 14);
    len = int_sqrt(c[0] * c[0] + c[1] * c[1] + c[2] * c[2]);
    r = '{0, 0, 0};
    w = '{0, 0, 0};
    if (len != 0) begin
      for (int k = 0; k < 3; k++) r[k] = unit_part(c[k], len);
      w[0] = clamp_sym(rnd_q(r[1] * f[2] - r[2] * f[1], 14), VOne);
      w[1] = clamp_sym(rnd_q(r[2] * f[0] - r[0] * f[2], 14), VOne);
      w[2] = clamp_sym(rnd_q(r[0] * f[1] - r[1] * f[0], 14), VOne);
    end else begin
      n_flat++;
    end
    for (int k = 0; k < 3; k++) begin
      v.side[k] = r[k][15:0];
      v.upw[k]  = w[k][15:0];
      v.back[k] = 16'(-f[k]);
    end
    // side and up translations clamp symmetrically, the back one to the full range
    v.sh_side = 32'(clamp_sym(-eye_dot(r[0], r[1], r[2]), Lim32));
    v.sh_up   = 32'(clamp_sym(-eye_dot(w[0], w[1], w[2]), Lim32));
    t = eye_dot(f[0], f[1], f[2]);
    if (t > Lim32) t = Lim32;
    if (t < -Lim32 - 1) t = -Lim32 - 1;
    v.sh_back = 32'(t);
    return v;
  endfunction

  function automatic void check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      n_fail++;
    end
  endfunction

  // monitor: register writes, input transactions and result transactions
  always @(posedge clk_i) begin
    view_t e;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ecv_pkg::CFG_EYE_X: eye[0] = longint'($signed(cfg_data_i));
          ecv_pkg::CFG_EYE_Y: eye[1] = longint'($signed(cfg_data_i));
          ecv_pkg::CFG_EYE_Z: eye[2] = longint'($signed(cfg_data_i));
          ecv_pkg::CFG_UP_X:  wup[0] = longint'($signed(cfg_data_i[15:0]));
          ecv_pkg::CFG_UP_Y:  wup[1] = longint'($signed(cfg_data_i[15:0]));
          ecv_pkg::CFG_UP_Z:  wup[2] = longint'($signed(cfg_data_i[15:0]));
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        e = predict_view(yaw_offset_i, pitch_offset_i);
        if (row_origin) begin
          // eye at the origin: every translation is plainly zero
          e.sh_side = '0;
          e.sh_up   = '0;
          e.sh_back = '0;
        end
        view_q.push_back(e);
      end
      if (out_valid_o && !out_stall_i) begin
        n_seen++;
        if (view_q.size() == 0) begin
          $error("result transaction with no expectation waiting");
          n_fail++;
        end else begin
          e = view_q.pop_front();
          check_field("side_x", e.side[0], side_x_o);
          check_field("side_y", e.side[1], side_y_o);
          check_field("side_z", e.side[2], side_z_o);
          check_field("upward_x", e.upw[0], upward_x_o);
          check_field("upward_y", e.upw[1], upward_y_o);
          check_field("upward_z", e.upw[2], upward_z_o);
          check_field("back_x", e.back[0], back_x_o);
          check_field("back_y", e.back[1], back_y_o);
          check_field("back_z", e.back[2], back_z_o);
          check_field("shift_side", e.sh_side, shift_side_o);
          check_field("shift_up", e.sh_up, shift_up_o);
          check_field("shift_back", e.sh_back, shift_back_o);
        end
      end
    end
  end

  // receiver: short random stall bursts, and a long hold when asked
  always @(posedge clk_i) begin
    int stall_left, hold_left;
    if (!rst_ni) begin
      stall_left = 0;
      hold_left  = 0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (hold_req != hold_ack) begin
      hold_ack  = hold_req;
      hold_left = LongHold;
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 3);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // watchdog: cycles in which no transaction of any kind happens
  always @(posedge clk_i) begin
    int quiet_cyc;
    if (!rst_ni || cfg_we_i || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cyc = 0;
    else
      quiet_cyc++;
    if (quiet_cyc >= WatchLimit) begin
      $display("timeout with %0d results outstanding", view_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_item(logic [15:0] yaw, logic [15:0] pitch, bit origin);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    yaw_offset_i   <= yaw;
    pitch_offset_i <= pitch;
    row_origin     <= origin;
    do @(posedge clk_i); while (in_stall_o);
    n_sent++;
  endtask

  // settle the block before touching registers
  task automatic drain;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (view_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic write_end;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    n_phase++;
  endtask

  function automatic logic [31:0] pick_eye();
    case ($urandom_range(0, 5))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_up(logic [15:0] base);
    case ($urandom_range(0, 5))
      0:       return {16'($urandom_range(0, 16'hFFFF)), base};
      1:       return {16'h0000, 16'sd16384};
      2:       return {16'hFFFF, -16'sd16384};
      3:       return $urandom;  // out of range, saturated inside
      default: return {16'h0000, 16'($urandom_range(0, 32768) - 16384)};
    endcase
  endfunction

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'h4000;  // quarter turn, front may meet world up
      2:       return 16'hC000;
      3:       return 16'h7FFF;
      4:       return 16'h8000;
      5:       return 16'($urandom_range(0, 64) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  row_t dir_rows[] = '{
    '{16'h0000, 16'h0000, 1'b1},  // state straight after reset
    '{16'h7FFF, 16'h7FFF, 1'b1},
    '{16'h8000, 16'h8000, 1'b1},
    '{16'h4000, 16'h0000, 1'b1},
    '{16'h0000, 16'h4000, 1'b1},  // quarter-turn pitch offset, bringing pitch just short of ninety
    '{16'h0001, 16'h0000, 1'b1},
    '{16'hFFFF, 16'h2000, 1'b1},  // pitch past ninety
    '{16'h0000, 16'h8000, 1'b1},
    '{16'h1234, 16'hC000, 1'b1}
  };

  row_t ext_rows[] = '{
    '{16'h0000, 16'h0000, 1'b0},
    '{16'h2000, 16'h1000, 1'b0},
    '{16'h8000, 16'h7FFF, 1'b0},
    '{16'hC000, 16'h4000, 1'b0},
    '{16'h5555, 16'hAAAA, 1'b0},
    '{16'h7FFF, 16'h8001, 1'b0}
  };

  initial begin
    eye       = '{0, 0, 0};
    wup       = '{0, 16384, 0};
    yaw_ang   = 16'hC000;
    pitch_ang = 16'h0000;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset registers, then extremes of eye and world up
    foreach (dir_rows[i]) send_item(dir_rows[i].yaw, dir_rows[i].pitch, dir_rows[i].origin);
    drain();
    write_reg(ecv_pkg::CFG_EYE_X, 32'h7FFF_FFFF);
    write_reg(ecv_pkg::CFG_EYE_Y, 32'h8000_0000);
    write_reg(ecv_pkg::CFG_EYE_Z, 32'h7FFF_FFFF);
    write_reg(ecv_pkg::CFG_UP_X, 32'h0000_7FFF);
    write_reg(ecv_pkg::CFG_UP_Y, 32'hFFFF_8000);
    write_reg(ecv_pkg::CFG_UP_Z, 32'h0000_4000);
    write_reg(CfgSpare6, 32'hFFFF_FFFF);
    write_reg(CfgSpare7, 32'h1234_5678);
    write_end();
    foreach (ext_rows[i]) send_item(ext_rows[i].yaw, ext_rows[i].pitch, ext_rows[i].origin);
    drain();
    write_reg(ecv_pkg::CFG_EYE_X, 32'h8000_0000);
    write_reg(ecv_pkg::CFG_EYE_Y, 32'h8000_0000);
    write_reg(ecv_pkg::CFG_EYE_Z, 32'h8000_0000);
    write_reg(ecv_pkg::CFG_UP_X, 32'h0000_0000);
    write_reg(ecv_pkg::CFG_UP_Y, 32'hFFFF_C000);
    write_reg(ecv_pkg::CFG_UP_Z, 32'h0000_0000);
    write_end();
    foreach (ext_rows[i]) send_item(ext_rows[i].yaw, ext_rows[i].pitch, ext_rows[i].origin);

    // random phases, each with fresh registers
    for (int p = 0; p < 6; p++) begin
      drain();
      write_reg(ecv_pkg::CFG_EYE_X, pick_eye());
      write_reg(ecv_pkg::CFG_EYE_Y, pick_eye());
      write_reg(ecv_pkg::CFG_EYE_Z, pick_eye());
      write_reg(ecv_pkg::CFG_UP_X, pick_up(16'h0000));
      write_reg(ecv_pkg::CFG_UP_Y, pick_up(16'h4000));
      write_reg(ecv_pkg::CFG_UP_Z, pick_up(16'h0000));
      if ($urandom_range(0, 1)) write_reg(3'($urandom_range(CfgSpare6, CfgSpare7)), $urandom);
      write_end();
      if (p == 1) hold_req++;  // long receiver hold while items keep coming
      if (p == 5) calm = 1'b1;
      for (int k = 0; k < RandItems / 6; k++) send_item(pick_angle(), pick_angle(), 1'b0);
    end

    in_valid_i <= 1'b0;
    while (view_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d camera updates over %0d register settings, %0d with front along up",
             n_sent, n_phase, n_flat);
    $display("%0d view matrices checked, %0d mismatches", n_seen, n_fail);
    if (n_fail == 0 && view_q.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
